// ----- rtl/iml_pkg.sv -----
// shared definitions for the ising metropolis lattice engine
// field widths, operation and register codes, reset constants, control structs
// no dependencies
package iml_pkg;

    localparam int LATTICE_SIZE = 32;

    localparam int OP_W        = 2;
    localparam int POS_W       = 5;
    localparam int RND_W       = 16;
    localparam int ENERGY_W    = 13;
    localparam int MAG_W       = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
    localparam logic [OP_W-1:0] OP_TRIAL     = 2'd1;
    localparam logic [OP_W-1:0] OP_RECOMPUTE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_THR_FOUR  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_EIGHT = 4'd1;

    localparam logic [CFG_DATA_W-1:0] THR_FOUR_RESET  = 16'd12378;
    localparam logic [CFG_DATA_W-1:0] THR_EIGHT_RESET = 16'd2338;

    typedef logic signed [ENERGY_W-1:0] t_energy;
    typedef logic signed [MAG_W-1:0]    t_mag;

    typedef struct packed {
        logic capture;
        logic walk_start;
        logic clear_wr;
        logic walk_step;
        logic rd_site;
        logic rd_vert;
        logic rd_right;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_last;
    } t_stat;

endpackage

// ----- rtl/iml_ctrl.sv -----
// sequencer for the ising lattice engine: clear sweep, trial reads, recompute walk
// depends on iml_pkg; drives iml_datapath through t_cmd, watches t_stat
module iml_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [iml_pkg::OP_W-1:0]  i_operation,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output iml_pkg::t_cmd             o_cmd,
    input  iml_pkg::t_stat            i_stat
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_RD3   = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.walk_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_operation)
                        iml_pkg::OP_LOAD: n_state = S_FIN;
                        iml_pkg::OP_RECOMPUTE: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                        default: n_state = S_RD1;
                    endcase
                end
            end
            S_RD1: begin
                o_cmd.rd_site = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_vert = 1'b1;
                n_state       = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_right = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_FIN;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_FIN;
            S_FIN: begin
                // hold the finished item until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.finish | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again before the item finished");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid)
        else $error("finished item did not raise output valid");

    a_one_port_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rd_site, o_cmd.rd_vert, o_cmd.rd_right, o_cmd.walk_step,
                  o_cmd.clear_wr, o_cmd.finish}))
        else $error("two lattice memory users in one cycle");
`endif

endmodule

// ----- rtl/iml_datapath.sv -----
// datapath of the ising lattice engine: spin memory, totals, thresholds, trial logic
// depends on iml_pkg; commanded by iml_ctrl
module iml_datapath #(
    parameter int LATTICE_SIZE = iml_pkg::LATTICE_SIZE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iml_pkg::t_cmd                     i_cmd,
    output iml_pkg::t_stat                    o_stat,
    input  logic [iml_pkg::OP_W-1:0]          i_operation,
    input  logic [iml_pkg::POS_W-1:0]         i_row,
    input  logic [iml_pkg::POS_W-1:0]         i_column,
    input  logic                              i_spin_in,
    input  logic [iml_pkg::RND_W-1:0]         i_random_value,
    input  logic                              i_cfg_valid,
    input  logic [iml_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [iml_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic signed [iml_pkg::ENERGY_W-1:0] o_energy,
    output logic signed [iml_pkg::MAG_W-1:0]  o_magnetization,
    output logic                              o_flipped,
    output logic                              o_site_spin
);

    localparam int CW    = $clog2(LATTICE_SIZE);
    localparam int DEPTH = LATTICE_SIZE * LATTICE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DE_W  = 5;

    typedef logic [CW-1:0] t_coord;
    typedef logic [AW-1:0] t_addr;

    localparam t_coord          LAST         = t_coord'(LATTICE_SIZE - 1);
    localparam iml_pkg::t_energy ENERGY_RESET = iml_pkg::t_energy'(-2 * DEPTH);
    localparam iml_pkg::t_mag    MAG_RESET    = iml_pkg::t_mag'(DEPTH);
    localparam iml_pkg::t_mag    MAG_STEP     = iml_pkg::t_mag'(2);

    // input coordinates reduced onto the lattice
    function automatic t_coord coord_mod(input logic [iml_pkg::POS_W-1:0] v);
        t_coord res;
        res = '0;
        for (int k = 0; k < 2 ** iml_pkg::POS_W; k++) begin
            if (v == iml_pkg::POS_W'(k)) res = t_coord'(k % LATTICE_SIZE);
        end
        return res;
    endfunction

    function automatic t_coord wrap_inc(input t_coord p);
        return (p == LAST) ? '0 : p + t_coord'(1);
    endfunction

    function automatic t_coord wrap_dec(input t_coord p);
        return (p == '0) ? LAST : p - t_coord'(1);
    endfunction

    function automatic t_addr site_addr(input t_coord row, input t_coord col);
        return t_addr'(row) * t_addr'(LATTICE_SIZE) + t_addr'(col);
    endfunction

    // bond energy contribution: -1 for aligned spins, +1 otherwise
    function automatic iml_pkg::t_energy bond(input logic a, input logic b);
        return (a == b) ? iml_pkg::t_energy'(-1) : iml_pkg::t_energy'(1);
    endfunction

    logic [iml_pkg::OP_W-1:0]       r_op;
    t_coord                         r_row;
    t_coord                         r_col;
    logic                           r_spin_in;
    logic [iml_pkg::RND_W-1:0]      r_rnd;
    logic [iml_pkg::CFG_DATA_W-1:0] r_thr4;
    logic [iml_pkg::CFG_DATA_W-1:0] r_thr8;
    iml_pkg::t_energy               r_energy;
    iml_pkg::t_mag                  r_mag;

    logic                           r_spin_mem [DEPTH];
    logic                           r_rd_a;
    logic                           r_rd_b;
    logic                           r_ph_site;
    logic                           r_ph_vert;

    logic                           r_s;
    logic                           r_nl;
    logic                           r_nu;
    logic                           r_nd;
    logic                           r_flip;
    logic signed [DE_W-1:0]         r_de;

    t_coord                         r_wr;
    t_coord                         r_wc;
    logic                           r_wv;
    t_coord                         r_wr_d;
    t_coord                         r_wc_d;
    logic                           r_first;
    logic                           r_prev;
    iml_pkg::t_energy               r_acc_e;
    iml_pkg::t_mag                  r_acc_m;

    iml_pkg::t_energy               r_o_energy;
    iml_pkg::t_mag                  r_o_mag;
    logic                           r_o_flipped;
    logic                           r_o_site;

    t_addr                          site;
    t_addr                          addr_a;
    t_addr                          addr_b;
    logic                           re;
    t_addr                          waddr;
    logic                           wdata;
    logic                           we;
    logic                           step;

    logic [2:0]                     eq;
    logic                           accept;
    logic signed [DE_W:0]           de_wide;

    iml_pkg::t_energy               n_energy;
    iml_pkg::t_mag                  n_mag;
    logic                           n_site;
    logic                           n_flipped;
    iml_pkg::t_energy               n_acc_e;
    iml_pkg::t_mag                  n_acc_m;

    assign site = site_addr(r_row, r_col);
    assign step = i_cmd.clear_wr | i_cmd.walk_step;
    assign o_stat.walk_last = (r_wr == LAST) && (r_wc == LAST);

    // read port addressing
    always_comb begin
        addr_a = site;
        addr_b = site;
        re     = 1'b1;
        if (i_cmd.rd_site) begin
            addr_b = site_addr(r_row, wrap_dec(r_col));
        end else if (i_cmd.rd_vert) begin
            addr_a = site_addr(wrap_dec(r_row), r_col);
            addr_b = site_addr(wrap_inc(r_row), r_col);
        end else if (i_cmd.rd_right) begin
            addr_a = site_addr(r_row, wrap_inc(r_col));
        end else if (i_cmd.walk_step) begin
            addr_a = site_addr(r_wr, r_wc);
            addr_b = site_addr(wrap_inc(r_wr), r_wc);
        end else begin
            re = 1'b0;
        end
    end

    // write port: clearing sweep or item write-back
    always_comb begin
        waddr = site;
        wdata = 1'b1;
        we    = 1'b0;
        if (i_cmd.clear_wr) begin
            waddr = site_addr(r_wr, r_wc);
            we    = 1'b1;
        end else if (i_cmd.finish) begin
            unique case (r_op)
                iml_pkg::OP_LOAD: begin
                    wdata = r_spin_in;
                    we    = 1'b1;
                end
                iml_pkg::OP_TRIAL: begin
                    wdata = ~r_s;
                    we    = r_flip;
                end
                default: we = 1'b0;
            endcase
        end
    end

    // trial decision, right neighbor arrives on port a
    always_comb begin
        eq = 3'({2'b00, r_nl == r_s} + {2'b00, r_nu == r_s}
               + {2'b00, r_nd == r_s} + {2'b00, r_rd_a == r_s});
        unique case (eq)
            3'd3:    accept = r_rnd < r_thr4;
            3'd4:    accept = r_rnd < r_thr8;
            default: accept = 1'b1;
        endcase
        de_wide = $signed({1'b0, eq, 2'b00}) - 6'sd8;
    end

    // totals and result for the item being finished
    always_comb begin
        n_energy  = r_energy;
        n_mag     = r_mag;
        n_site    = r_s;
        n_flipped = 1'b0;
        unique case (r_op)
            iml_pkg::OP_LOAD: n_site = r_spin_in;
            iml_pkg::OP_TRIAL: begin
                n_site    = r_s ^ r_flip;
                n_flipped = r_flip;
                if (r_flip) begin
                    n_energy = r_energy + iml_pkg::t_energy'(r_de);
                    n_mag    = r_s ? r_mag - MAG_STEP : r_mag + MAG_STEP;
                end
            end
            iml_pkg::OP_RECOMPUTE: begin
                n_energy = r_acc_e;
                n_mag    = r_acc_m;
            end
            default: n_site = r_s;
        endcase
    end

    // recompute accumulation: vertical bond, bond to the left, wrap bond at row end
    always_comb begin
        n_acc_e = r_acc_e + bond(r_rd_a, r_rd_b)
                + ((r_wc_d != '0) ? bond(r_prev, r_rd_a) : '0)
                + ((r_wc_d == LAST) ? bond(r_rd_a, r_first) : '0);
        n_acc_m = r_acc_m + (r_rd_a ? iml_pkg::t_mag'(1) : iml_pkg::t_mag'(-1));
    end

    always_ff @(posedge i_clk) begin
        if (we) r_spin_mem[waddr] <= wdata;
        if (re) begin
            r_rd_a <= r_spin_mem[addr_a];
            r_rd_b <= r_spin_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr4    <= iml_pkg::THR_FOUR_RESET;
            r_thr8    <= iml_pkg::THR_EIGHT_RESET;
            r_energy  <= ENERGY_RESET;
            r_mag     <= MAG_RESET;
            r_wr      <= '0;
            r_wc      <= '0;
            r_wv      <= 1'b0;
            r_ph_site <= 1'b0;
            r_ph_vert <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    iml_pkg::CFG_THR_FOUR:  r_thr4 <= i_cfg_data;
                    iml_pkg::CFG_THR_EIGHT: r_thr8 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_energy <= n_energy;
                r_mag    <= n_mag;
            end
            if (i_cmd.walk_start) begin
                r_wr <= '0;
                r_wc <= '0;
            end else if (step) begin
                if (r_wc == LAST) begin
                    r_wc <= '0;
                    r_wr <= wrap_inc(r_wr);
                end else begin
                    r_wc <= r_wc + t_coord'(1);
                end
            end
            r_wv      <= i_cmd.walk_step;
            r_ph_site <= i_cmd.rd_site;
            r_ph_vert <= i_cmd.rd_vert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_row     <= coord_mod(i_row);
            r_col     <= coord_mod(i_column);
            r_spin_in <= i_spin_in;
            r_rnd     <= i_random_value;
            r_flip    <= 1'b0;
        end
        if (i_cmd.walk_start) begin
            r_acc_e <= '0;
            r_acc_m <= '0;
        end
        if (r_ph_site) begin
            r_s  <= r_rd_a;
            r_nl <= r_rd_b;
        end
        if (r_ph_vert) begin
            r_nu <= r_rd_a;
            r_nd <= r_rd_b;
        end
        if (i_cmd.eval) begin
            r_flip <= (r_op == iml_pkg::OP_TRIAL) && accept;
            r_de   <= de_wide[DE_W-1:0];
        end
        if (i_cmd.walk_step) begin
            r_wr_d <= r_wr;
            r_wc_d <= r_wc;
        end
        if (r_wv) begin
            r_acc_e <= n_acc_e;
            r_acc_m <= n_acc_m;
            r_prev  <= r_rd_a;
            if (r_wc_d == '0) r_first <= r_rd_a;
            // addressed site passes by during the walk
            if (r_wr_d == r_row && r_wc_d == r_col) r_s <= r_rd_a;
        end
        if (i_cmd.finish) begin
            r_o_energy  <= n_energy;
            r_o_mag     <= n_mag;
            r_o_flipped <= n_flipped;
            r_o_site    <= n_site;
        end
    end

    assign o_energy        = r_o_energy;
    assign o_magnetization = r_o_mag;
    assign o_flipped       = r_o_flipped;
    assign o_site_spin     = r_o_site;

endmodule

// ----- rtl/ising_metropolis_lattice.sv -----
// top level of the ising lattice metropolis engine
// depends on iml_pkg, iml_ctrl and iml_datapath
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_operation i_row i_column
//                                                  i_spin_in i_random_value
//  output    out        o_out_valid / i_out_ready  o_energy o_magnetization
//                                                  o_flipped o_site_spin
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// one item at a time; a load goes from idle straight to its finish step, a trial makes
// three reads of the spin memory (two read ports), one decision step and one write-back,
// recompute walks one site per cycle through the memory ports, then drains and finishes
// after reset a clearing pass sets every spin up, with the input held not ready;
// a finished item waits in its finish state while the output register is full and not taken
module ising_metropolis_lattice #(
    parameter int LATTICE_SIZE = iml_pkg::LATTICE_SIZE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [iml_pkg::OP_W-1:0]             i_operation,
    input  logic [iml_pkg::POS_W-1:0]            i_row,
    input  logic [iml_pkg::POS_W-1:0]            i_column,
    input  logic                                 i_spin_in,
    input  logic [iml_pkg::RND_W-1:0]            i_random_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [iml_pkg::ENERGY_W-1:0]  o_energy,
    output logic signed [iml_pkg::MAG_W-1:0]     o_magnetization,
    output logic                                 o_flipped,
    output logic                                 o_site_spin,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [iml_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [iml_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    iml_pkg::t_cmd  cmd;
    iml_pkg::t_stat stat;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    iml_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    iml_datapath #(
        .LATTICE_SIZE (LATTICE_SIZE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_spin_in       (i_spin_in),
        .i_random_value  (i_random_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_energy        (o_energy),
        .o_magnetization (o_magnetization),
        .o_flipped       (o_flipped),
        .o_site_spin     (o_site_spin)
    );

endmodule

// ----- tb/sv/tb_ising_metropolis_lattice.sv -----
// testbench for ising_metropolis_lattice: directed and random lattice operations
// with random threshold settings and random idling on both channels
// depends on iml_pkg and the ising_metropolis_lattice rtl
`timescale 1ns / 100ps

module tb_ising_metropolis_lattice;

    import iml_pkg::*;

    localparam logic [OP_W-1:0]        OP_SPARE  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'hF;
    localparam int SITES        = LATTICE_SIZE * LATTICE_SIZE;
    localparam int PHASES       = 6;
    localparam int PHASE_OPS    = 88;
    localparam int TAIL_CYCLES  = 16;

    typedef struct packed {
        logic [OP_W-1:0]  code;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             spin;
        logic [RND_W-1:0] rnd;
    } t_lattice_op;

    typedef struct packed {
        t_energy energy;
        t_mag    magnet;
        logic    flipped;
        logic    site_spin;
    } t_lattice_result;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_thr_write;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_lattice_op cur_op     = '0;
    logic [OP_W-1:0]  i_operation;
    logic [POS_W-1:0] i_row;
    logic [POS_W-1:0] i_column;
    logic             i_spin_in;
    logic [RND_W-1:0] i_random_value;

    logic    o_out_valid;
    logic    i_out_ready = 1'b0;
    t_energy o_energy;
    t_mag    o_magnetization;
    logic    o_flipped;
    logic    o_site_spin;

    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    assign i_operation    = cur_op.code;
    assign i_row          = cur_op.row;
    assign i_column       = cur_op.col;
    assign i_spin_in      = cur_op.spin;
    assign i_random_value = cur_op.rnd;

    // mirror of the lattice, totals and thresholds
    bit               spin_mirror [SITES];
    t_energy          energy_mirror;
    t_mag             magnet_mirror;
    logic [RND_W-1:0] thr_four;
    logic [RND_W-1:0] thr_eight;

    t_lattice_op     op_q[$];
    t_lattice_result expected_totals_q[$];
    t_thr_write      thr_write_q[$];

    int  ops_outstanding    = 0;
    int  writes_outstanding = 0;
    int  errors             = 0;
    int  in_gap             = 0;
    int  out_stall          = 0;
    bit  in_calm            = 1'b0;
    bit  out_calm           = 1'b0;
    bit  in_take;
    bit  out_take;
    bit  cfg_take;

    ising_metropolis_lattice DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_spin_in      (i_spin_in),
        .i_random_value (i_random_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_energy       (o_energy),
        .o_magnetization(o_magnetization),
        .o_flipped      (o_flipped),
        .o_site_spin    (o_site_spin),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("ising_metropolis_lattice test failed");
        $finish;
    end

    task automatic report(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // spin as +1 / -1 with periodic wrap on both coordinates
    function automatic int spin_at(input int r, input int c);
        int rr;
        int cc;
        rr = (r + LATTICE_SIZE) % LATTICE_SIZE;
        cc = (c + LATTICE_SIZE) % LATTICE_SIZE;
        return spin_mirror[rr * LATTICE_SIZE + cc] ? 1 : -1;
    endfunction

    function automatic t_lattice_result apply_lattice_op(input t_lattice_op item);
        t_lattice_result res;
        int r;
        int c;
        int idx;
        int s;
        int nsum;
        int de;
        int e;
        int m;
        bit flip_ok;
        r   = int'(item.row) % LATTICE_SIZE;
        c   = int'(item.col) % LATTICE_SIZE;
        idx = r * LATTICE_SIZE + c;
        res.flipped = 1'b0;
        case (item.code)
            OP_LOAD: begin
                spin_mirror[idx] = item.spin;
            end
            OP_TRIAL: begin
                s    = spin_at(r, c);
                nsum = spin_at(r, c - 1) + spin_at(r, c + 1)
                     + spin_at(r - 1, c) + spin_at(r + 1, c);
                de   = 2 * s * nsum;
                if (de <= 0) begin
                    flip_ok = 1'b1;
                end else if (de == 4) begin
                    flip_ok = item.rnd < thr_four;
                end else begin
                    flip_ok = item.rnd < thr_eight;
                end
                if (flip_ok) begin
                    spin_mirror[idx] = !spin_mirror[idx];
                    energy_mirror    = energy_mirror + t_energy'(de);
                    magnet_mirror    = magnet_mirror - t_mag'(2 * s);
                    res.flipped      = 1'b1;
                end
            end
            OP_RECOMPUTE: begin
                e = 0;
                m = 0;
                for (int rr = 0; rr < LATTICE_SIZE; rr++) begin
                    for (int cc = 0; cc < LATTICE_SIZE; cc++) begin
                        s = spin_at(rr, cc);
                        e -= s * (spin_at(rr + 1, cc) + spin_at(rr, cc + 1));
                        m += s;
                    end
                end
                energy_mirror = t_energy'(e);
                magnet_mirror = t_mag'(m);
            end
            default: ;
        endcase
        res.energy    = energy_mirror;
        res.magnet    = magnet_mirror;
        res.site_spin = spin_mirror[idx];
        return res;
    endfunction

    // half back to back, most of the rest short gaps, a few long ones
    function automatic int next_gap(input bit calm);
        int p;
        if (calm) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 50) begin
            return 0;
        end
        if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // each coordinate comes half the time from the window around the wrap
    function automatic logic [POS_W-1:0] random_pos();
        if ($urandom_range(0, 1) == 0) begin
            return POS_W'((LATTICE_SIZE - 2 + $urandom_range(0, 3)) % LATTICE_SIZE);
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic t_lattice_op random_op();
        t_lattice_op item;
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) begin
            item.code = OP_TRIAL;
        end else if (p < 92) begin
            item.code = OP_LOAD;
        end else if (p < 94) begin
            item.code = OP_RECOMPUTE;
        end else begin
            item.code = OP_SPARE;
        end
        item.row  = random_pos();
        item.col  = random_pos();
        item.spin = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            6:       item.rnd = '0;
            7:       item.rnd = '1;
            8:       item.rnd = thr_four - RND_W'($urandom_range(0, 1));
            9:       item.rnd = thr_eight - RND_W'($urandom_range(0, 1));
            default: item.rnd = RND_W'($urandom);
        endcase
        return item;
    endfunction

    task automatic push_op(input logic [OP_W-1:0] code, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic spin,
                           input logic [RND_W-1:0] rnd);
        op_q.push_back('{code: code, row: row, col: col, spin: spin, rnd: rnd});
        ops_outstanding++;
    endtask

    task automatic push_write(input logic [CFG_INDEX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] data);
        thr_write_q.push_back('{index: index, data: data});
        writes_outstanding++;
    endtask

    task automatic wait_idle();
        while (ops_outstanding != 0 || writes_outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // input driver: one transfer per accepted op, prediction taken at the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_take = i_in_valid && o_in_ready;
            if (in_take) begin
                expected_totals_q.push_back(apply_lattice_op(cur_op));
                if ($urandom_range(0, 39) == 0) begin
                    in_calm = !in_calm;
                end
            end
            if (!i_in_valid || in_take) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (op_q.size() > 0) begin
                    cur_op     <= op_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap      = next_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // threshold register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            cfg_take = i_cfg_valid && o_cfg_ready;
            if (cfg_take) begin
                case (i_cfg_index)
                    CFG_THR_FOUR:  thr_four  = i_cfg_data;
                    CFG_THR_EIGHT: thr_eight = i_cfg_data;
                    default: ;
                endcase
                writes_outstanding--;
            end
            if (!i_cfg_valid || cfg_take) begin
                if (thr_write_q.size() > 0) begin
                    {i_cfg_index, i_cfg_data} <= thr_write_q.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge i_clk) begin
        t_lattice_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            out_take = o_out_valid && i_out_ready;
            if (out_take) begin
                if (expected_totals_q.size() == 0) begin
                    report("result transfer with no expectation pending");
                end else begin
                    want = expected_totals_q.pop_front();
                    if (o_energy !== want.energy) begin
                        report($sformatf("energy got %0d want %0d", o_energy, want.energy));
                    end
                    if (o_magnetization !== want.magnet) begin
                        report($sformatf("magnetization got %0d want %0d",
                                         o_magnetization, want.magnet));
                    end
                    if (o_flipped !== want.flipped) begin
                        report($sformatf("flipped got %b want %b", o_flipped, want.flipped));
                    end
                    if (o_site_spin !== want.site_spin) begin
                        report($sformatf("site spin got %b want %b",
                                         o_site_spin, want.site_spin));
                    end
                    ops_outstanding--;
                end
                if ($urandom_range(0, 39) == 0) begin
                    out_calm = !out_calm;
                end
                out_stall = next_gap(out_calm);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] four;
        logic [CFG_DATA_W-1:0] eight;

        foreach (spin_mirror[k]) begin
            spin_mirror[k] = 1'b1;
        end
        energy_mirror = t_energy'(-2 * SITES);
        magnet_mirror = t_mag'(SITES);
        thr_four      = THR_FOUR_RESET;
        thr_eight     = THR_EIGHT_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all spins up: energy change of eight at every site
        push_op(OP_TRIAL, 0, 0, 1'b0, 16'hFFFF);
        push_op(OP_TRIAL, 0, 0, 1'b1, THR_EIGHT_RESET - 16'd1);
        push_op(OP_TRIAL, 0, 0, 1'b0, 16'hFFFF);
        push_op(OP_TRIAL, 0, 0, 1'b0, THR_EIGHT_RESET);
        // one down neighbor across the wrap gives a change of four
        push_op(OP_LOAD, 31, 31, 1'b0, 16'h0000);
        push_op(OP_TRIAL, 0, 31, 1'b1, THR_FOUR_RESET);
        push_op(OP_TRIAL, 0, 31, 1'b0, THR_FOUR_RESET - 16'd1);
        push_op(OP_TRIAL, 0, 31, 1'b1, 16'hFFFF);
        // two down neighbors give a change of zero, always flips
        push_op(OP_LOAD, 1, 31, 1'b0, 16'hFFFF);
        push_op(OP_TRIAL, 0, 31, 1'b0, 16'hFFFF);
        push_op(OP_TRIAL, 0, 31, 1'b1, 16'hFFFF);
        push_op(OP_RECOMPUTE, 31, 31, 1'b1, 16'h0000);
        push_op(OP_SPARE, 31, 0, 1'b1, 16'hFFFF);
        push_op(OP_LOAD, 0, 0, 1'b1, 16'h5555);
        push_op(OP_TRIAL, 31, 0, 1'b0, 16'h0000);
        // all four neighbors down, loads leave the totals stale until recompute
        push_op(OP_LOAD, 15, 14, 1'b0, 16'hAAAA);
        push_op(OP_LOAD, 15, 16, 1'b0, 16'h0000);
        push_op(OP_LOAD, 14, 15, 1'b0, 16'h0000);
        push_op(OP_LOAD, 16, 15, 1'b0, 16'h0000);
        push_op(OP_TRIAL, 15, 15, 1'b1, 16'hFFFF);
        push_op(OP_TRIAL, 15, 15, 1'b0, 16'hFFFF);
        push_op(OP_RECOMPUTE, 0, 0, 1'b0, 16'h0000);
        push_op(OP_SPARE, 0, 31, 1'b0, 16'h0000);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    four  = '0;
                    eight = '0;
                end
                1: begin
                    four  = '1;
                    eight = '1;
                end
                2: begin
                    four  = CFG_DATA_W'($urandom);
                    eight = CFG_DATA_W'($urandom);
                end
                3: begin
                    four  = 16'h8000;
                    eight = '0;
                end
                4: begin
                    four  = THR_FOUR_RESET;
                    eight = THR_EIGHT_RESET;
                end
                default: begin
                    four  = CFG_DATA_W'($urandom);
                    eight = CFG_DATA_W'($urandom_range(0, 4095));
                end
            endcase
            push_write(CFG_THR_FOUR, four);
            push_write(CFG_THR_EIGHT, eight);
            // unknown index must leave both thresholds alone
            if (phase % 2 == 1) begin
                push_write(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            wait_idle();
            for (int n = 0; n < PHASE_OPS; n++) begin
                op_q.push_back(random_op());
                ops_outstanding++;
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_totals_q.size() == 0) begin
            $display("ising_metropolis_lattice test passed");
        end else begin
            $display("ising_metropolis_lattice test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/iml_pkg.sv
rtl/iml_ctrl.sv
rtl/iml_datapath.sv
rtl/ising_metropolis_lattice.sv
tb/sv/tb_ising_metropolis_lattice.sv
